// ===== rtl/core/bitmap_font_text_renderer_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap font text renderer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// checked only out of reset
`define BFTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define BFTR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bftr_pkg.sv =====
// ----------------------------------------------------------------------------
// bftr_pkg
// constants shared by the bitmap font text renderer and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package bftr_pkg;

  localparam int FONT_BYTES_DEF = 8192;
  localparam int GLYPH_ROWS_DEF = 16;
  localparam int GLYPH_WIDTH    = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_BASE   = 3'd0;
  localparam cfg_idx_t REG_LINE_STRIDE  = 3'd1;
  localparam cfg_idx_t REG_SCREEN_WIDTH = 3'd2;
  localparam cfg_idx_t REG_GLYPH_BYTES  = 3'd3;
  localparam cfg_idx_t REG_TEXT_COLOR   = 3'd4;

  localparam logic [31:0] FRAME_BASE_RST   = 32'd0;
  localparam logic [13:0] LINE_STRIDE_RST  = 14'd1024;
  localparam logic [13:0] SCREEN_WIDTH_RST = 14'd1024;
  localparam logic [5:0]  GLYPH_BYTES_RST  = 6'd16;
  localparam logic [31:0] TEXT_COLOR_RST   = 32'h00FF_FFFF;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PUT  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_font_text_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer
// draws 8 pixel wide glyphs from a loadable font memory at a text cursor
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready    func, font_address, font_byte, char_code
//   out      output     out_valid / out_ready  pixel_address, row_mask, pixel_color, last_row
//   cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// a font load request writes one font byte; a character passes its setup steps (newline
// cursor update, y times stride multiply, address add with cursor advance) and then one
// font memory read per glyph row.
// reset is synchronous: cursor and registers clear, font memory is not cleared.
// out_ready low holds up to two rows (read and output registers) and pauses reads.
// FONT_BYTES must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_font_text_renderer #(
  parameter int FONT_BYTES = bftr_pkg::FONT_BYTES_DEF,
  parameter int GLYPH_ROWS = bftr_pkg::GLYPH_ROWS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [12:0]                   in_font_address,
  input  wire logic [7:0]                    in_font_byte,
  input  wire logic [7:0]                    in_char_code,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [31:0]                        out_pixel_address,
  output logic [7:0]                         out_row_mask,
  output logic [31:0]                        out_pixel_color,
  output logic                               out_last_row,
  input  wire logic                          cfg_we,
  input  wire bftr_pkg::cfg_idx_t            cfg_index,
  input  wire logic [bftr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bftr_pkg::*;

  localparam int AW = $clog2(FONT_BYTES);
  localparam int RW = $clog2(GLYPH_ROWS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_ROWS = 2'd3;

  logic [31:0] frame_base_r;
  logic [13:0] line_stride_r;
  logic [13:0] screen_width_r;
  logic [5:0]  glyph_bytes_r;
  logic [31:0] text_color_r;

  logic [1:0]  state_r;
  logic [12:0] cursor_x_r;
  logic [15:0] cursor_y_r;
  logic [13:0] base_byte_r;
  logic [29:0] prod_r;
  logic [31:0] addr_r;
  logic [RW-1:0] row_r;

  logic [7:0]  font_mem [FONT_BYTES];
  logic        rd_pend_r;
  logic [7:0]  rd_data_r;
  logic [31:0] rd_px_r;
  logic        rd_last_r;

  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [7:0]  out_mask_r;
  logic        out_last_r;

  logic          accept;
  logic          mem_we;
  logic          move;
  logic          issue;
  logic          is_last;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic [16:0]   rd_sum;
  logic [13:0]   next_x;
  logic          wrap;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign mem_we   = accept && (in_func == FUNC_LOAD);
  assign move     = rd_pend_r && (!out_valid_r || out_ready);
  assign issue    = (state_r == ST_ROWS) && (!rd_pend_r || move);
  assign is_last  = (row_r == RW'(GLYPH_ROWS - 1));
  assign wr_idx   = AW'(in_font_address);
  assign rd_sum   = {3'b0, base_byte_r} + 17'(row_r);
  assign rd_idx   = rd_sum[AW-1:0];
  assign next_x   = {1'b0, cursor_x_r} + 14'(GLYPH_WIDTH);
  assign wrap     = ({1'b0, next_x} + 15'(GLYPH_WIDTH)) > {1'b0, screen_width_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r   <= FRAME_BASE_RST;
      line_stride_r  <= LINE_STRIDE_RST;
      screen_width_r <= SCREEN_WIDTH_RST;
      glyph_bytes_r  <= GLYPH_BYTES_RST;
      text_color_r   <= TEXT_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_BASE:   frame_base_r   <= cfg_wdata;
        REG_LINE_STRIDE:  line_stride_r  <= cfg_wdata[13:0];
        REG_SCREEN_WIDTH: screen_width_r <= cfg_wdata[13:0];
        REG_GLYPH_BYTES:  glyph_bytes_r  <= cfg_wdata[5:0];
        REG_TEXT_COLOR:   text_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // font memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[wr_idx] <= in_font_byte;
    end
    if (issue) begin
      rd_data_r <= font_mem[rd_idx];
    end
  end

  // sequencer and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      row_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_func == FUNC_PUT)) begin
            if (in_char_code == NEWLINE_CODE) begin
              cursor_x_r <= '0;
              cursor_y_r <= cursor_y_r + 16'(GLYPH_ROWS);
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          if (wrap) begin
            cursor_x_r <= '0;
            cursor_y_r <= cursor_y_r + 16'(GLYPH_ROWS);
          end else begin
            cursor_x_r <= next_x[12:0];
          end
          row_r   <= '0;
          state_r <= ST_ROWS;
        end
        ST_ROWS: begin
          if (issue) begin
            row_r <= row_r + 1'b1;
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // address datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      base_byte_r <= {6'b0, in_char_code} * {8'b0, glyph_bytes_r};
    end
    if (state_r == ST_MUL) begin
      prod_r <= 30'(cursor_y_r) * 30'(line_stride_r);
    end
    if (state_r == ST_ADD) begin
      addr_r <= frame_base_r + 32'(prod_r) + 32'(cursor_x_r);
    end else if (issue) begin
      addr_r <= addr_r + 32'(line_stride_r);
    end
    if (issue) begin
      rd_px_r   <= addr_r;
      rd_last_r <= is_last;
    end
    if (move) begin
      out_addr_r <= rd_px_r;
      out_mask_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  // read and output valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        rd_pend_r <= 1'b1;
      end else if (move) begin
        rd_pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_row_mask      = out_mask_r;
  assign out_pixel_color   = text_color_r;
  assign out_last_row      = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/bftr_checker.sv =====
// ----------------------------------------------------------------------------
// bftr_checker
// port level checks for the bitmap font text renderer
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_font_text_renderer_macros.svh"

module bftr_checker #(
  parameter int GLYPH_ROWS = bftr_pkg::GLYPH_ROWS_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            in_func,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [31:0]                     out_pixel_address,
  input wire logic                            out_last_row
);
  import bftr_pkg::*;

  localparam int CW = $clog2(GLYPH_ROWS);

  logic [CW-1:0] row_cnt_r;
  logic          out_take;
  logic          cnt_at_last;

  assign out_take    = out_valid && out_ready;
  assign cnt_at_last = (row_cnt_r == CW'(GLYPH_ROWS - 1));

  // rows delivered since the last row of the previous character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
    end else if (out_take) begin
      if (out_last_row) begin
        row_cnt_r <= '0;
      end else begin
        row_cnt_r <= row_cnt_r + 1'b1;
      end
    end
  end

  `BFTR_ASSERT_RST(a_reset_idle, !rst_n |=> in_ready && !out_valid, "not idle after reset")
  `BFTR_ASSERT(a_put_busy, in_valid && in_ready && (in_func == FUNC_PUT) |=> !in_ready, "put request not blocking")
  `BFTR_ASSERT(a_last_row_count, out_take |-> (out_last_row == cnt_at_last), "last row flag misplaced")
  `BFTR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pixel_address), "stalled row changed")

endmodule

bind bitmap_font_text_renderer bftr_checker #(.GLYPH_ROWS(GLYPH_ROWS)) u_bftr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_func          (in_func),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pixel_address(out_pixel_address),
  .out_last_row     (out_last_row)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bitmap font text renderer: font loads and
// character requests go in under random gaps, glyph rows come out under
// random stalls and one long hold-off, and every row is checked against a
// cycle-free model of cursor, font memory and address arithmetic
// ----------------------------------------------------------------------------
module testbench;
  import bftr_pkg::*;

  localparam int ROWS          = GLYPH_ROWS_DEF;
  localparam int FONT_SIZE     = FONT_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic        func;
    logic [12:0] font_address;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
  } text_req_t;

  typedef struct packed {
    logic [31:0] pixel_address;
    logic [7:0]  row_mask;
    logic [31:0] pixel_color;
    logic        last_row;
  } glyph_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [12:0]           in_font_address;
  logic [7:0]            in_font_byte;
  logic [7:0]            in_char_code;
  logic                  out_valid;
  logic                  out_ready;
  logic [31:0]           out_pixel_address;
  logic [7:0]            out_row_mask;
  logic [31:0]           out_pixel_color;
  logic                  out_last_row;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bitmap_font_text_renderer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_font_address   (in_font_address),
    .in_font_byte      (in_font_byte),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_row_mask      (out_row_mask),
    .out_pixel_color   (out_pixel_color),
    .out_last_row      (out_last_row),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // model state
  logic [7:0]  font_copy [0:FONT_SIZE-1];
  logic [12:0] cur_x;
  logic [15:0] cur_y;
  logic [31:0] base_reg;
  logic [13:0] stride_reg;
  logic [13:0] width_reg;
  logic [5:0]  glyph_bytes_reg;
  logic [31:0] color_reg;

  text_req_t  pending_reqs [$];
  glyph_row_t rows_due [$];
  bit         font_planned [0:FONT_SIZE-1];
  logic [7:0] used_codes [$];

  text_req_t  cur_req;
  glyph_row_t want_row;
  logic       in_taken;
  logic       offer;
  logic       rdy;
  int         send_idle;
  int         stall_left;
  int         hold_left;
  bit         hold_armed;
  bit         gaps_on;
  bit         stalls_on;

  int cycle_cnt;
  int queued_cnt;
  int accepted_cnt;
  int chars_done;
  int loads_done;
  int rows_checked;
  int phase_cnt;
  int err_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[bitmap_font_text_renderer] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 50)
      $display("mismatch %s: got %h, expected %h (row %0d, t=%0t)",
               what, got, want, rows_checked, $time);
    err_cnt++;
  endtask

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // glyph rows for one character request, cursor advanced afterwards
  task automatic draw_char(input logic [7:0] code);
    logic [31:0] base_byte;
    logic [31:0] font_sum;
    logic [31:0] y;
    logic [31:0] next_x;
    glyph_row_t  r;
    if (code == NEWLINE_CODE) begin
      cur_x = '0;
      cur_y = cur_y + 16'(ROWS);
    end
    base_byte = 32'(code) * 32'(glyph_bytes_reg);
    for (int row = 0; row < ROWS; row++) begin
      font_sum        = base_byte + 32'(row);
      y               = 32'(cur_y) + 32'(row);
      r.pixel_address = base_reg + y * 32'(stride_reg) + 32'(cur_x);
      r.row_mask      = font_copy[font_sum[12:0]];
      r.pixel_color   = color_reg;
      r.last_row      = (row == ROWS - 1);
      rows_due.push_back(r);
    end
    next_x = 32'(cur_x) + 32'(GLYPH_WIDTH);
    if (next_x + 32'(GLYPH_WIDTH) > 32'(width_reg)) begin
      cur_x = '0;
      cur_y = cur_y + 16'(ROWS);
    end else begin
      cur_x = next_x[12:0];
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      in_taken = 1'b1;
      accepted_cnt++;
      if (cur_req.func == FUNC_LOAD) begin
        font_copy[cur_req.font_address] = cur_req.font_byte;
        loads_done++;
      end else begin
        draw_char(cur_req.char_code);
        chars_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        report_mismatch("row with nothing due", out_pixel_address, '0);
      end else begin
        want_row = rows_due.pop_front();
        if (out_pixel_address !== want_row.pixel_address)
          report_mismatch("pixel_address", out_pixel_address, want_row.pixel_address);
        if (out_row_mask !== want_row.row_mask)
          report_mismatch("row_mask", 32'(out_row_mask), 32'(want_row.row_mask));
        if (out_pixel_color !== want_row.pixel_color)
          report_mismatch("pixel_color", out_pixel_color, want_row.pixel_color);
        if (out_last_row !== want_row.last_row)
          report_mismatch("last_row", 32'(out_last_row), 32'(want_row.last_row));
        rows_checked++;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    offer = in_valid;
    if (in_taken) begin
      offer     = 1'b0;
      in_taken  = 1'b0;
      send_idle = gaps_on ? idle_len() : 0;
    end
    if (!offer && rst_n) begin
      if (send_idle > 0) begin
        send_idle--;
      end else if (pending_reqs.size() > 0) begin
        cur_req         = pending_reqs.pop_front();
        offer           = 1'b1;
        in_func         <= cur_req.func;
        in_font_address <= cur_req.font_address;
        in_font_byte    <= cur_req.font_byte;
        in_char_code    <= cur_req.char_code;
      end
    end
    in_valid <= offer;
  end

  // row receiver
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
      if (stalls_on && $urandom_range(0, 9) < 3) stall_left = idle_len();
    end
    out_ready <= rdy;
  end

  task automatic push_load(input logic [12:0] addr, input logic [7:0] data);
    text_req_t r;
    r.func         = FUNC_LOAD;
    r.font_address = addr;
    r.font_byte    = data;
    r.char_code    = 8'($urandom);
    pending_reqs.push_back(r);
    font_planned[addr] = 1'b1;
    queued_cnt++;
  endtask

  // loads any glyph byte not yet written, then the character itself
  task automatic push_char(input logic [7:0] code);
    text_req_t   r;
    logic [31:0] idx;
    for (int row = 0; row < ROWS; row++) begin
      idx = 32'(code) * 32'(glyph_bytes_reg) + 32'(row);
      if (!font_planned[idx[12:0]]) push_load(idx[12:0], 8'($urandom));
    end
    r.func         = FUNC_PUT;
    r.font_address = 13'($urandom);
    r.font_byte    = 8'($urandom);
    r.char_code    = code;
    pending_reqs.push_back(r);
    queued_cnt++;
  endtask

  task automatic push_random(input int budget);
    int         start;
    int         pick;
    logic [7:0] code;
    start = queued_cnt;
    used_codes.delete();
    while (queued_cnt - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        push_load(13'($urandom_range(0, FONT_SIZE - 1)), 8'($urandom));
      end else begin
        if (pick < 25)
          code = NEWLINE_CODE;
        else if (pick < 60 && used_codes.size() > 0)
          code = used_codes[$urandom_range(0, used_codes.size() - 1)];
        else
          code = 8'($urandom_range(0, 255));
        push_char(code);
        used_codes.push_back(code);
      end
    end
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || rows_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FRAME_BASE:   base_reg        = val;
      REG_LINE_STRIDE:  stride_reg      = val[13:0];
      REG_SCREEN_WIDTH: width_reg       = val[13:0];
      REG_GLYPH_BYTES:  glyph_bytes_reg = val[5:0];
      REG_TEXT_COLOR:   color_reg       = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] base, input logic [31:0] stride,
                          input logic [31:0] width, input logic [31:0] gbytes,
                          input logic [31:0] color);
    wait_idle();
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_SCREEN_WIDTH, width);
    write_reg(REG_GLYPH_BYTES, gbytes);
    write_reg(REG_TEXT_COLOR, color);
    phase_cnt++;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = 1'b0;
    in_font_address = '0;
    in_font_byte    = '0;
    in_char_code    = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_FRAME_BASE;
    cfg_wdata       = '0;
    in_taken        = 1'b0;
    send_idle       = 0;
    stall_left      = 0;
    hold_left       = 0;
    hold_armed      = 1'b0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    cycle_cnt       = 0;
    queued_cnt      = 0;
    accepted_cnt    = 0;
    chars_done      = 0;
    loads_done      = 0;
    rows_checked    = 0;
    phase_cnt       = 0;
    err_cnt         = 0;
    cur_x           = '0;
    cur_y           = '0;
    base_reg        = FRAME_BASE_RST;
    stride_reg      = LINE_STRIDE_RST;
    width_reg       = SCREEN_WIDTH_RST;
    glyph_bytes_reg = GLYPH_BYTES_RST;
    color_reg       = TEXT_COLOR_RST;
    for (int i = 0; i < FONT_SIZE; i++) begin
      font_copy[i]    = '0;
      font_planned[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // glyph size zero: every character reads bytes 0 to 15, narrow screen wraps fast
    set_regs(32'h0, 32'd1024, 32'd24, 32'd0, 32'h8000_0001);
    push_load(13'd0, 8'h00);
    push_load(13'd1, 8'hFF);
    push_load(13'd2, 8'h80);
    push_load(13'd3, 8'h01);
    push_load(13'd4, 8'h55);
    push_load(13'd5, 8'hAA);
    for (int i = 6; i < ROWS; i++) push_load(13'(i), 8'($urandom));
    push_load(13'h1FFF, 8'hFF);
    push_char(8'd0);
    push_char(8'd255);
    push_char(NEWLINE_CODE);
    push_char(8'd128);
    push_char(NEWLINE_CODE);
    push_char(8'd65);
    push_char(8'd127);

    set_regs(32'h1000_0000, 32'd640, 32'd640, 32'd16, $urandom);
    push_random(20);
    hold_armed = 1'b1;

    set_regs(32'hFFFF_FFF0, 32'd8192, 32'd8192, 32'd32, 32'hFFFF_FFFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    push_random(15);

    set_regs($urandom, 32'd1, 32'd8, 32'd8, 32'h0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    push_random(15);

    // out-of-range settings: zero stride and width, largest glyph size
    set_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd63, $urandom);
    push_random(10);

    set_regs($urandom, $urandom_range(1, 8192), $urandom_range(8, 8192),
             $urandom_range(16, 32), $urandom);
    push_random(15);

    wait_idle();
    $display("covered %0d requests: %0d characters and %0d font loads over %0d settings",
             accepted_cnt, chars_done, loads_done, phase_cnt);
    $display("checked %0d glyph rows with %0d mismatches", rows_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("[bitmap_font_text_renderer] OK");
    end else begin
      $display("[bitmap_font_text_renderer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bftr_pkg.sv
rtl/core/bitmap_font_text_renderer.sv
rtl/core/bftr_checker.sv
tb/testbench.sv
